>>> rtl/core/cwi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cwi_pkg
// Shared types, field widths and defaults of the wavetable interpolator.
// ----------------------------------------------------------------------------
package cwi_pkg;

  // fixed field widths of the ports
  localparam int TIME_W    = 32;
  localparam int ACT_W     = 3;
  localparam int ENTRY_W   = 8;
  localparam int VALUE_W   = 16;
  localparam int USED_W    = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 32;
  localparam int STEP_W    = 6;

  // parameter defaults
  localparam int NUM_ACTUATORS_DEF = 8;
  localparam int TABLE_SIZE_DEF    = 256;
  localparam int VALUE_BITS_DEF    = 16;

  // register reset values
  localparam logic [TIME_W-1:0] CYCLE_LENGTH_RST   = 32'd1000000;
  localparam logic [USED_W-1:0] ACTUATORS_USED_RST = 4'd8;

  // fraction bits of the table position
  localparam int FRAC_W = 8;

  // depth of the queue between front and back
  localparam int Q_DEPTH = 2;

  // item kinds
  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_WRITE  = 1'b1
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CYCLE_LENGTH   = 1'b0,
    REG_ACTUATORS_USED = 1'b1
  } cfg_reg_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV_REM,
    BK_SCALE,
    BK_DIV_POS,
    BK_RD,
    BK_MUL,
    BK_OUT
  } back_state_t;

  // request to the serial divider
  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] rem0;
    logic [TIME_W-1:0] dividend;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  // answer of the serial divider
  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] quotient;
    logic [TIME_W-1:0] remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> rtl/core/cwi_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cwi_front
// Accepts input words, drops out-of-range table writes, forms table addresses
// and packs the word for the queue.
// ----------------------------------------------------------------------------
module cwi_front
  import cwi_pkg::*;
#(
  parameter int NUM_ACTUATORS = NUM_ACTUATORS_DEF,
  parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF,
  localparam int AW  = $clog2(NUM_ACTUATORS * TABLE_SIZE),
  localparam int QDW = 1 + TIME_W + AW + VALUE_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_command,
  input  wire logic [TIME_W-1:0]         in_sample_time,
  input  wire logic [ACT_W-1:0]          in_entry_actuator,
  input  wire logic [ENTRY_W-1:0]        in_entry_index,
  input  wire logic signed [VALUE_W-1:0] in_entry_value,
  input  wire logic                      q_full,
  output logic                           q_push,
  output logic [QDW-1:0]                 q_wdata
);

  localparam int AXW = AW + ACT_W + ENTRY_W;

  op_t                  op;
  logic                 in_range;
  logic                 keep;
  logic [AXW-1:0]       addr_full;
  logic [AW-1:0]        wr_addr;
  logic [VALUE_BITS-1:0] wr_val;

  // classify the word
  always_comb begin
    op       = op_t'(in_command);
    in_range = (int'(in_entry_actuator) < NUM_ACTUATORS) &&
               (int'(in_entry_index) < TABLE_SIZE);
    keep     = (op == OP_SAMPLE) || in_range;
  end

  // table address and stored value of a write
  always_comb begin
    addr_full = AXW'(in_entry_actuator) * AXW'(TABLE_SIZE) + AXW'(in_entry_index);
    wr_addr   = addr_full[AW-1:0];
    wr_val    = VALUE_BITS'($unsigned(in_entry_value));
  end

  // queue handshake
  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready && keep;
  assign q_wdata  = {op, in_sample_time, wr_addr, wr_val};

  // an ignored write never reaches the queue
  a_drop_bad_write: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && (op == OP_WRITE)) |-> in_range)
    else $error("out-of-range table write pushed");

endmodule
`default_nettype wire

>>> rtl/core/cwi_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cwi_queue
// Short first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
module cwi_queue
  import cwi_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  full,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      rdata
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  logic [WIDTH-1:0] slot_r [Q_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r,  count_nxt;

  assign full      = (count_r == CW'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("push into full queue");

endmodule
`default_nettype wire

>>> rtl/core/cwi_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cwi_divider
// Restoring divider, one quotient bit per cycle, shared by the period
// reduction and the phase-to-position scaling.
// ----------------------------------------------------------------------------
module cwi_divider
  import cwi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire div_req_t          req,
  input  wire logic [TIME_W-1:0] divisor,
  output div_rsp_t               rsp
);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [TIME_W-1:0] rem_r;
  logic [TIME_W-1:0] num_r;
  logic [TIME_W-1:0] quo_r;
  logic [TIME_W:0]   rem_sh;
  logic [TIME_W:0]   rem_sub;
  logic              q_bit;

  // one shift-compare-subtract step
  always_comb begin
    rem_sh  = {rem_r, num_r[TIME_W-1]};
    rem_sub = rem_sh - {1'b0, divisor};
    q_bit   = (rem_sh >= {1'b0, divisor});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == STEP_W'(1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt_r <= req.steps;
      rem_r <= req.rem0;
      num_r <= req.dividend;
      quo_r <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      rem_r <= q_bit ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
      num_r <= {num_r[TIME_W-2:0], 1'b0};
      quo_r <= {quo_r[TIME_W-2:0], q_bit};
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < divisor))
    else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

>>> rtl/core/cwi_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cwi_back
// Executes queued words: writes the wave table, reduces the sample time to a
// phase, scales it to a table position and interpolates each actuator.
// ----------------------------------------------------------------------------
module cwi_back
  import cwi_pkg::*;
#(
  parameter int NUM_ACTUATORS = NUM_ACTUATORS_DEF,
  parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF,
  localparam int AW  = $clog2(NUM_ACTUATORS * TABLE_SIZE),
  localparam int QDW = 1 + TIME_W + AW + VALUE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_valid,
  input  wire logic [QDW-1:0]         q_rdata,
  output logic                        q_pop,
  input  wire logic [TIME_W-1:0]      cycle_len,
  input  wire logic [USED_W-1:0]      act_used,
  output div_req_t                    div_req,
  input  wire div_rsp_t               div_rsp,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [ACT_W-1:0]            out_actuator_index,
  output logic signed [VALUE_W-1:0]   out_drive_value,
  output logic                        out_last_of_run
);

  localparam int MEM_DEPTH = NUM_ACTUATORS * TABLE_SIZE;
  localparam int IW        = $clog2(TABLE_SIZE);
  localparam int QW        = IW + FRAC_W;
  localparam int SW        = TIME_W + QW;
  localparam int AXW       = AW + USED_W;
  localparam int VB        = VALUE_BITS;

  // unpacked queue word
  op_t                 q_op;
  logic [TIME_W-1:0]   q_time;
  logic [AW-1:0]       q_addr;
  logic [VB-1:0]       q_val;

  assign q_op   = op_t'(q_rdata[QDW-1]);
  assign q_time = q_rdata[QDW-2 -: TIME_W];
  assign q_addr = q_rdata[AW+VB-1 -: AW];
  assign q_val  = q_rdata[VB-1:0];

  back_state_t          state_r,   state_nxt;
  logic                 started_r, started_nxt;
  logic [TIME_W-1:0]    start_r,   start_nxt;
  logic [TIME_W-1:0]    t_r,       t_nxt;
  logic [USED_W-1:0]    n_r,       n_nxt;
  logic [USED_W-1:0]    i_r,       i_nxt;
  logic [SW-1:0]        scale_r,   scale_nxt;
  logic [IW-1:0]        idx_r,     idx_nxt;
  logic [FRAC_W-1:0]    frac_r,    frac_nxt;
  logic signed [VB+9:0] prod_r,    prod_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic [ACT_W-1:0]     out_act_r;
  logic [VB-1:0]        out_y_r;
  logic                 out_last_r;

  logic                 mem_we;
  logic                 out_load;
  logic                 is_last;
  logic [TIME_W-1:0]    elapsed;
  logic [IW-1:0]        nxt_idx;
  logic [AXW-1:0]       row_base;
  logic [AW-1:0]        rd_addr_a;
  logic [AW-1:0]        rd_addr_b;
  logic signed [VB:0]   diff;
  logic signed [VB+1:0] y_full;
  logic [VB-1:0]        y_low;

  logic [VB-1:0]        wave_mem [MEM_DEPTH];
  logic [VB-1:0]        ya_r;
  logic [VB-1:0]        yb_r;

  // read addresses of the two neighboring entries
  always_comb begin
    nxt_idx   = (idx_r == IW'(TABLE_SIZE - 1)) ? '0 : idx_r + 1'b1;
    row_base  = AXW'(i_r) * AXW'(TABLE_SIZE);
    rd_addr_a = AW'(row_base + AXW'(idx_r));
    rd_addr_b = AW'(row_base + AXW'(nxt_idx));
  end

  // interpolation arithmetic
  always_comb begin
    diff     = $signed({yb_r[VB-1], yb_r}) - $signed({ya_r[VB-1], ya_r});
    prod_nxt = diff * $signed({1'b0, frac_r});
    y_full   = $signed({{2{ya_r[VB-1]}}, ya_r}) + (VB+2)'(prod_r >>> FRAC_W);
    y_low    = y_full[VB-1:0];
  end

  assign elapsed  = q_time - (started_r ? start_r : q_time);
  assign out_load = !out_vld_r || out_ready;
  assign is_last  = (i_r == n_r - 1'b1);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    started_nxt = started_r;
    start_nxt   = start_r;
    t_nxt       = t_r;
    n_nxt       = n_r;
    i_nxt       = i_r;
    scale_nxt   = scale_r;
    idx_nxt     = idx_r;
    frac_nxt    = frac_r;
    out_vld_nxt = out_vld_r && !out_ready;
    q_pop       = 1'b0;
    mem_we      = 1'b0;
    div_req     = '0;
    case (state_r)
      BK_IDLE: begin
        q_pop = q_valid;
        if (q_valid && (q_op == OP_WRITE)) begin
          mem_we = 1'b1;
        end else if (q_valid) begin
          // reduce elapsed time modulo the period
          div_req.start    = 1'b1;
          div_req.rem0     = '0;
          div_req.dividend = elapsed;
          div_req.steps    = STEP_W'(TIME_W);
          t_nxt            = q_time;
          n_nxt            = (int'(act_used) > NUM_ACTUATORS) ?
                             USED_W'(NUM_ACTUATORS) : act_used;
          state_nxt        = BK_DIV_REM;
        end
      end
      BK_DIV_REM: begin
        if (div_rsp.done) begin
          started_nxt = 1'b1;
          start_nxt   = t_r - div_rsp.remainder;
          scale_nxt   = SW'(div_rsp.remainder) * SW'(TABLE_SIZE * (1 << FRAC_W));
          state_nxt   = BK_SCALE;
        end
      end
      BK_SCALE: begin
        // position = phase * table span / period
        div_req.start    = 1'b1;
        div_req.rem0     = scale_r[SW-1:QW];
        div_req.dividend = {scale_r[QW-1:0], {(TIME_W-QW){1'b0}}};
        div_req.steps    = STEP_W'(QW);
        state_nxt        = BK_DIV_POS;
      end
      BK_DIV_POS: begin
        if (div_rsp.done) begin
          idx_nxt   = div_rsp.quotient[QW-1:FRAC_W];
          frac_nxt  = div_rsp.quotient[FRAC_W-1:0];
          i_nxt     = '0;
          state_nxt = (n_r == '0) ? BK_IDLE : BK_RD;
        end
      end
      BK_RD: begin
        state_nxt = BK_MUL;
      end
      BK_MUL: begin
        state_nxt = BK_OUT;
      end
      BK_OUT: begin
        if (out_load) begin
          out_vld_nxt = 1'b1;
          i_nxt       = i_r + 1'b1;
          state_nxt   = is_last ? BK_IDLE : BK_RD;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      started_r <= 1'b0;
      start_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      started_r <= started_nxt;
      start_r   <= start_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    t_r     <= t_nxt;
    n_r     <= n_nxt;
    i_r     <= i_nxt;
    scale_r <= scale_nxt;
    idx_r   <= idx_nxt;
    frac_r  <= frac_nxt;
    prod_r  <= prod_nxt;
  end

  // output word register
  always_ff @(posedge clk) begin
    if ((state_r == BK_OUT) && out_load) begin
      out_act_r  <= ACT_W'(i_r);
      out_y_r    <= y_low;
      out_last_r <= is_last;
    end
  end

  // wave table, one write port and two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      wave_mem[q_addr] <= q_val;
    end
    ya_r <= wave_mem[rd_addr_a];
    yb_r <= wave_mem[rd_addr_b];
  end

  assign out_valid          = out_vld_r;
  assign out_actuator_index = out_act_r;
  assign out_drive_value    = VALUE_W'(out_y_r);
  assign out_last_of_run    = out_last_r;

  a_act_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_RD) |-> (i_r < n_r))
    else $error("actuator counter past run length");

  a_started_before_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_RD) |-> started_r)
    else $error("table read before period start latched");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> ((state_r == BK_DIV_REM) || (state_r == BK_DIV_POS)))
    else $error("divider result arrived while not waited for");

endmodule
`default_nettype wire

>>> rtl/core/cyclic_wavetable_interpolator.sv
// Table write words pass through the queue and are written into the table while
// the back end is idle, one word per cycle.
// Sample words run on the bit-serial divider: a 32-step period reduction, a
// 16-step position scaling (at 256 entries), then per actuator the table read,
// multiply and add states; a stalled output holds the add state.
// Synchronous active-low reset clears config, timing state, queue and output.
`default_nettype none
// ----------------------------------------------------------------------------
// cyclic_wavetable_interpolator
// Periodic wavetable oscillator with linear interpolation for a set of
// actuators, fed by table writes and time samples.
// ----------------------------------------------------------------------------
module cyclic_wavetable_interpolator
  import cwi_pkg::*;
#(
  parameter int NUM_ACTUATORS = NUM_ACTUATORS_DEF,
  parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // input words
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_command,
  input  wire logic [TIME_W-1:0]         in_sample_time,
  input  wire logic [ACT_W-1:0]          in_entry_actuator,
  input  wire logic [ENTRY_W-1:0]        in_entry_index,
  input  wire logic signed [VALUE_W-1:0] in_entry_value,
  // result words
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [ACT_W-1:0]               out_actuator_index,
  output logic signed [VALUE_W-1:0]      out_drive_value,
  output logic                           out_last_of_run,
  // configuration writes
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DAT_W-1:0]      cfg_data
);

  localparam int AW  = $clog2(NUM_ACTUATORS * TABLE_SIZE);
  localparam int QDW = 1 + TIME_W + AW + VALUE_BITS;

  logic [TIME_W-1:0] cycle_length_r;
  logic [USED_W-1:0] actuators_used_r;
  logic [TIME_W-1:0] cycle_len;

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_valid;
  logic [QDW-1:0]    q_wdata;
  logic [QDW-1:0]    q_rdata;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_length_r   <= CYCLE_LENGTH_RST;
      actuators_used_r <= ACTUATORS_USED_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_CYCLE_LENGTH:   cycle_length_r   <= cfg_data[TIME_W-1:0];
        REG_ACTUATORS_USED: actuators_used_r <= cfg_data[USED_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // a zero period behaves as one tick
  assign cycle_len = (cycle_length_r == '0) ? TIME_W'(1) : cycle_length_r;

  cwi_front #(
    .NUM_ACTUATORS (NUM_ACTUATORS),
    .TABLE_SIZE    (TABLE_SIZE),
    .VALUE_BITS    (VALUE_BITS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_sample_time    (in_sample_time),
    .in_entry_actuator (in_entry_actuator),
    .in_entry_index    (in_entry_index),
    .in_entry_value    (in_entry_value),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_wdata           (q_wdata)
  );

  cwi_queue #(
    .WIDTH (QDW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .rdata     (q_rdata)
  );

  cwi_divider u_divider (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .divisor (cycle_len),
    .rsp     (div_rsp)
  );

  cwi_back #(
    .NUM_ACTUATORS (NUM_ACTUATORS),
    .TABLE_SIZE    (TABLE_SIZE),
    .VALUE_BITS    (VALUE_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_rdata            (q_rdata),
    .q_pop              (q_pop),
    .cycle_len          (cycle_len),
    .act_used           (actuators_used_r),
    .div_req            (div_req),
    .div_rsp            (div_rsp),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_actuator_index (out_actuator_index),
    .out_drive_value    (out_drive_value),
    .out_last_of_run    (out_last_of_run)
  );

endmodule
`default_nettype wire

>>> test/tb_cyclic_wavetable_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cyclic_wavetable_interpolator
// Self-checking bench for the wavetable interpolator. Table entries are
// written just before the first sample that reads them, then directed and
// random sample and table-write words run under several register settings.
// Each drive word is compared with a bit-accurate prediction kept by a small
// scoreboard.
// ----------------------------------------------------------------------------
module tb_cyclic_wavetable_interpolator;
  import cwi_pkg::*;

  localparam int NACT           = NUM_ACTUATORS_DEF;
  localparam int NENT           = TABLE_SIZE_DEF;
  localparam int SETTLE_CYCLES  = 200;
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PHASES  = 8;
  localparam int ITEM_TARGET    = 230;

  // one drive word as the block emits it
  typedef struct packed {
    logic [ACT_W-1:0]          actuator;
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } drive_word_t;

  // predicts drive words from accepted input words and checks the block
  class drive_scoreboard;
    logic [TIME_W-1:0]         cycle_len;
    logic [USED_W-1:0]         used;
    logic [TIME_W-1:0]         phase_origin;
    logic                      running;
    logic signed [VALUE_W-1:0] wave [NACT][NENT];
    bit                        written [NACT][NENT];
    drive_word_t               pending_drives[$];
    int                        mismatches;

    function new();
      cycle_len    = CYCLE_LENGTH_RST;
      used         = ACTUATORS_USED_RST;
      phase_origin = '0;
      running      = 1'b0;
      mismatches   = 0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [CFG_DAT_W-1:0] d);
      case (r)
        REG_CYCLE_LENGTH:   cycle_len = d;
        REG_ACTUATORS_USED: used = d[USED_W-1:0];
        default: ;
      endcase
    endfunction

    // number of actuators a sample drives at the current settings
    function int active_count();
      return (used > NACT) ? NACT : int'(used);
    endfunction

    // table position a sample at time t would read, state left untouched
    function logic [ENTRY_W-1:0] peek_index(logic [TIME_W-1:0] t);
      logic [TIME_W-1:0] span;
      logic [TIME_W-1:0] origin;
      logic [TIME_W-1:0] elapsed;
      logic [63:0]       pos;
      span    = (cycle_len == '0) ? TIME_W'(1) : cycle_len;
      origin  = running ? phase_origin : t;
      elapsed = (t - origin) % span;
      pos     = (64'(elapsed) << (FRAC_W + ENTRY_W)) / 64'(span);
      return pos[FRAC_W +: ENTRY_W];
    endfunction

    function void note_word(op_t cmd, logic [TIME_W-1:0] t, logic [ACT_W-1:0] act,
                            logic [ENTRY_W-1:0] ent, logic signed [VALUE_W-1:0] val);
      logic [TIME_W-1:0]  span;
      logic [TIME_W-1:0]  elapsed;
      logic [63:0]        pos;
      logic [ENTRY_W-1:0] idx;
      logic [ENTRY_W-1:0] nxt;
      logic [FRAC_W-1:0]  frac;
      int                 n;
      int                 ya;
      int                 yb;
      drive_word_t        w;
      if (cmd == OP_WRITE) begin
        wave[act][ent]    = val;
        written[act][ent] = 1'b1;
        return;
      end
      // a zero period acts as one tick
      span = (cycle_len == '0) ? TIME_W'(1) : cycle_len;
      if (!running) begin
        phase_origin = t;
        running      = 1'b1;
      end
      // drop whole periods, start stays on a period boundary
      elapsed      = t - phase_origin;
      phase_origin = phase_origin + (elapsed / span) * span;
      elapsed      = elapsed % span;
      // table position with fraction bits
      pos  = (64'(elapsed) << (FRAC_W + ENTRY_W)) / 64'(span);
      idx  = pos[FRAC_W +: ENTRY_W];
      frac = pos[FRAC_W-1:0];
      nxt  = idx + 1'b1;
      n    = (used > NACT) ? NACT : used;
      // floor interpolation toward the next entry, wrapping at the end
      for (int i = 0; i < n; i++) begin
        ya         = wave[i][idx];
        yb         = wave[i][nxt];
        w.actuator = ACT_W'(i);
        w.value    = VALUE_W'(ya + (((yb - ya) * int'(frac)) >>> FRAC_W));
        w.last     = (i == n - 1);
        pending_drives.push_back(w);
      end
    endfunction

    function void check_drive(logic [ACT_W-1:0] act, logic signed [VALUE_W-1:0] val,
                              logic last);
      drive_word_t exp_w;
      if (pending_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected drive word: act %0d value %0d last %0b", act, val, last);
        return;
      end
      exp_w = pending_drives.pop_front();
      if (exp_w.actuator !== act || exp_w.value !== val || exp_w.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"drive mismatch: expected act %0d value %0d last %0b,",
                    " got act %0d value %0d last %0b"},
                   exp_w.actuator, exp_w.value, exp_w.last, act, val, last);
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_command;
  logic [TIME_W-1:0]         in_sample_time;
  logic [ACT_W-1:0]          in_entry_actuator;
  logic [ENTRY_W-1:0]        in_entry_index;
  logic signed [VALUE_W-1:0] in_entry_value;
  logic                      out_valid;
  logic                      out_ready;
  logic [ACT_W-1:0]          out_actuator_index;
  logic signed [VALUE_W-1:0] out_drive_value;
  logic                      out_last_of_run;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DAT_W-1:0]      cfg_data;

  drive_scoreboard sb;
  bit              idle_on = 1'b0;
  bit              hold_off_req = 1'b0;
  int              quiet_cycles = 0;
  int              items_sent = 0;

  cyclic_wavetable_interpolator dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_sample_time     (in_sample_time),
    .in_entry_actuator  (in_entry_actuator),
    .in_entry_index     (in_entry_index),
    .in_entry_value     (in_entry_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_actuator_index (out_actuator_index),
    .out_drive_value    (out_drive_value),
    .out_last_of_run    (out_last_of_run),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // table value with full-scale extremes now and then
  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // offer one input word, hold it until accepted, then sometimes idle a while
  task automatic push_word(input op_t cmd, input logic [TIME_W-1:0] t,
                           input logic [ACT_W-1:0] act, input logic [ENTRY_W-1:0] ent,
                           input logic [VALUE_W-1:0] val);
    int gap;
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_sample_time    <= t;
    in_entry_actuator <= act;
    in_entry_index    <= ent;
    in_entry_value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(cmd, t, act, ent, val);
    items_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // offer a sample word once every entry it reads is in the table
  task automatic push_sample(input logic [TIME_W-1:0] t, input logic [ACT_W-1:0] act,
                             input logic [ENTRY_W-1:0] ent,
                             input logic [VALUE_W-1:0] val);
    logic [ENTRY_W-1:0] idx;
    logic [ENTRY_W-1:0] nxt;
    int                 n;
    idx = sb.peek_index(t);
    nxt = idx + 1'b1;
    n   = sb.active_count();
    for (int a = 0; a < n; a++) begin
      if (!sb.written[a][idx])
        push_word(OP_WRITE, $urandom, ACT_W'(a), idx, pick_value());
      if (!sb.written[a][nxt])
        push_word(OP_WRITE, $urandom, ACT_W'(a), nxt, pick_value());
    end
    push_word(OP_SAMPLE, t, act, ent, val);
  endtask

  // register write, only issued while the block is idle
  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DAT_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(r, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // wait for every predicted word, then let silent work finish
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_drives.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // result sink with random stalls and one long hold-off on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // drive word monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_drive(out_actuator_index, out_drive_value, out_last_of_run);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    logic [TIME_W-1:0]  base_t;
    logic [TIME_W-1:0]  span;
    logic [TIME_W-1:0]  now_t;
    logic [USED_W-1:0]  used_sel;
    int                 phase_stop;
    sb                = new();
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_command        = 1'b0;
    in_sample_time    = '0;
    in_entry_actuator = '0;
    in_entry_index    = '0;
    in_entry_value    = '0;
    cfg_valid         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // actuators 0 and 1 get opposite full-scale values across the table wrap
    for (int a = 0; a < 2; a++) begin
      push_word(OP_WRITE, $urandom, ACT_W'(a), '0, (a == 0) ? 16'h8000 : 16'h7FFF);
      push_word(OP_WRITE, $urandom, ACT_W'(a), '1, (a == 0) ? 16'h7FFF : 16'h8000);
    end

    // directed words at reset settings
    idle_on = 1'b1;
    push_word(OP_WRITE, '1, 3'd7, 8'd255, 16'h8000);
    push_word(OP_WRITE, '0, 3'd7, 8'd0, 16'h7FFF);
    base_t = 32'h0000_1000;
    // first sample latches the period start
    push_sample(base_t, '0, '0, '0);
    // last position of the period, interpolates across the wrap
    push_sample(base_t + 32'd999_999, '1, '1, '1);
    push_sample(base_t + 32'd500_000, 3'd5, 8'hA5, 16'h5A5A);
    // start advances by three whole periods
    push_sample(base_t + 32'd3_000_000, '0, '0, '0);
    // time before the start wraps around
    push_sample(32'd0, '0, '0, '0);
    push_sample(32'hFFFF_FFFF, '1, '1, '1);
    settle();

    // zero period with no actuators: no words, timing still moves
    write_reg(REG_CYCLE_LENGTH, 32'd0);
    write_reg(REG_ACTUATORS_USED, 32'd0);
    push_sample(32'h8000_0000, '0, '0, '0);
    push_sample(32'h7FFF_FFFF, '1, '1, '1);
    settle();

    // actuator count above the limit saturates
    write_reg(REG_ACTUATORS_USED, 32'd15);
    push_sample(32'h1234_5678, '0, '0, '0);
    settle();

    // longest period, two actuators
    write_reg(REG_CYCLE_LENGTH, 32'hFFFF_FFFF);
    write_reg(REG_ACTUATORS_USED, 32'd2);
    push_sample(32'd0, '0, '0, '0);
    push_sample(32'hFFFF_FFFE, '0, '0, '0);
    push_sample(32'hFFFF_FFFF, '0, '0, '0);
    push_sample(32'h8000_0000, '0, '0, '0);
    settle();

    // shortest period, single actuator
    write_reg(REG_CYCLE_LENGTH, 32'd1);
    write_reg(REG_ACTUATORS_USED, 32'd1);
    push_sample(32'd77, '0, '0, '0);
    push_sample(32'd78, '0, '0, '0);
    settle();

    // random phases, each with its own settings and share of the word budget
    now_t = 32'hFFFF_0000;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: span = $urandom;
        1: span = $urandom_range(1, 300);
        2: span = $urandom_range(256, 100_000);
        default: span = (p == 3) ? 32'd1_000_000 : 32'hFFFF_FFFF;
      endcase
      used_sel = (p == 0) ? 4'd8 : (p == 5) ? 4'd12 : USED_W'($urandom_range(1, 4));
      write_reg(REG_CYCLE_LENGTH, span);
      write_reg(REG_ACTUATORS_USED, CFG_DAT_W'(used_sel));
      idle_on = (p != 1);
      phase_stop = items_sent + (ITEM_TARGET - items_sent) / (RANDOM_PHASES - p);
      if (phase_stop < items_sent + 4) phase_stop = items_sent + 4;
      // long receiver hold-off while words keep coming
      if (p == 2) hold_off_req = 1'b1;
      while (items_sent < phase_stop) begin
        if ($urandom_range(0, 99) < 65) begin
          // time mostly moves forward within a period, sometimes jumps
          case ($urandom_range(0, 9))
            0: now_t = $urandom;
            1, 2, 3: now_t = now_t + $urandom_range(0, 3);
            default: now_t = now_t + $urandom_range(0, span - 1);
          endcase
          push_sample(now_t, ACT_W'($urandom), ENTRY_W'($urandom), VALUE_W'($urandom));
        end else begin
          push_word(OP_WRITE, $urandom, ACT_W'($urandom), ENTRY_W'($urandom),
                    pick_value());
        end
      end
      settle();
    end

    // verdict
    if (sb.mismatches == 0 && sb.pending_drives.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
